/* rtl/core/sorted_table_binary_search_core_defines.svh */
// Assertion macros for the sorted table search core.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define STBS_ASSERT_NOW(label, clk, rst, cond, expect_now) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define STBS_ASSERT_NEXT(label, clk, rst, cond, expect_next) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/stbs_pkg.sv */
// Shared types and constants of the sorted table search core.
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int INDEX_WIDTH = $clog2(TABLE_DEPTH);
  localparam int COUNT_WIDTH = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_WIDTH   = 11;
  localparam int REG_IDX_WIDTH = 2;

  localparam logic [REG_IDX_WIDTH-1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_SIGNED_KEYS = 2'd1;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [9:0]  entry_index;
    logic [31:0] entry_value;
    logic [31:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [9:0] match_index;
  } out_item_t;

  typedef struct packed {
    logic write;
    logic load;
    logic step;
    logic emit;
  } stbs_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
  } stbs_status_t;

endpackage

/* rtl/core/stbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/stbs_datapath.sv */
// Search datapath: config registers, key table, probe window and result register.
module stbs_datapath
  import stbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [REG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data,
  input  in_item_t                 in_item,
  input  stbs_cmd_t                cmd,
  output stbs_status_t             status,
  output out_item_t                result
);

  logic [COUNT_WIDTH-1:0] entry_count;
  logic                   signed_keys;
  logic [KEY_WIDTH-1:0]   key;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] lim;
  logic [COUNT_WIDTH-1:0] probe;
  logic [COUNT_WIDTH-1:0] base_next;
  logic [COUNT_WIDTH-1:0] lim_next;
  logic [COUNT_WIDTH-1:0] probe_next;
  logic [KEY_WIDTH-1:0]   rdata;
  logic [KEY_WIDTH-1:0]   sign_flip;
  logic                   equal;
  logic                   greater;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      signed_keys <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENTRY_COUNT: begin
          entry_count <= (cfg_data > CFG_WIDTH'(TABLE_DEPTH))
                         ? COUNT_WIDTH'(TABLE_DEPTH) : COUNT_WIDTH'(cfg_data);
        end
        REG_SIGNED_KEYS: begin
          signed_keys <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  stbs_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.write),
    .waddr(in_item.entry_index[INDEX_WIDTH-1:0]),
    .wdata(in_item.entry_value[KEY_WIDTH-1:0]),
    .raddr(probe_next[INDEX_WIDTH-1:0]),
    .rdata(rdata)
  );

  assign sign_flip = {signed_keys, {(KEY_WIDTH-1){1'b0}}};
  assign equal     = (key == rdata);
  assign greater   = ((key ^ sign_flip) > (rdata ^ sign_flip));

  always_comb begin
    base_next = base;
    lim_next  = lim;
    if (cmd.load) begin
      base_next = '0;
      lim_next  = entry_count;
    end else if (greater) begin
      base_next = probe + COUNT_WIDTH'(1);
      lim_next  = (lim - COUNT_WIDTH'(1)) >> 1;
    end else begin
      lim_next  = lim >> 1;
    end
    probe_next = base_next + (lim_next >> 1);
  end

  assign status.hit       = cmd.step && equal;
  assign status.exhausted = (lim_next == '0);

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.step) begin
      base  <= base_next;
      lim   <= lim_next;
      probe <= probe_next;
    end
    if (cmd.load) begin
      key <= in_item.search_key[KEY_WIDTH-1:0];
    end
    if (cmd.emit) begin
      result.found       <= status.hit;
      result.match_index <= status.hit ? probe[INDEX_WIDTH-1:0] : '0;
    end
  end

endmodule

/* rtl/core/stbs_controller.sv */
// Search controller: accepts items and sequences the probe loop.
module stbs_controller
  import stbs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         mode,
  input  stbs_status_t status,
  output stbs_cmd_t    cmd,
  output logic         busy,
  output logic         result_valid
);

  typedef enum logic {
    IDLE,
    SEARCH
  } state_t;

  state_t state;
  logic   accept;

  assign busy   = (state == SEARCH);
  assign accept = start && !busy;

  always_comb begin
    cmd.write = accept && (mode == MODE_WRITE);
    cmd.load  = accept && (mode == MODE_SEARCH);
    cmd.step  = (state == SEARCH);
    cmd.emit  = (cmd.load && status.exhausted)
             || (cmd.step && (status.hit || status.exhausted));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      case (state)
        IDLE: begin
          if (cmd.load && !status.exhausted) begin
            state <= SEARCH;
          end
        end
        SEARCH: begin
          if (cmd.emit) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/sorted_table_binary_search_core.sv */
// Binary search over a sorted key table: a write item stores one key and gives no
// result; a search item over a non-empty table raises busy until its result. A search
// makes one table probe per cycle, one read of the key RAM each, and at most
// floor(log2(entry_count))+1 probes, eleven for 1024 entries; with an entry count of
// zero it makes none. The result strobe is registered from the controller's emit. The
// result is shown for exactly one cycle on result_valid and cannot be held off; a
// new item may be started in that same cycle. Write config only while idle.
module sorted_table_binary_search_core
  import stbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [REG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data,
  input  logic                     start,
  input  in_item_t                 in_item,
  output logic                     busy,
  output logic                     result_valid,
  output out_item_t                result
);

  stbs_cmd_t    cmd;
  stbs_status_t status;

  stbs_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (in_item.mode),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy),
    .result_valid(result_valid)
  );

  stbs_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule

/* rtl/core/stbs_checker.sv */
// Port-level assertions for the sorted table search core, bound to the top level.
`include "sorted_table_binary_search_core_defines.svh"

module stbs_checker
  import stbs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input in_item_t  in_item,
  input logic      busy,
  input logic      result_valid,
  input out_item_t result
);

  `STBS_ASSERT_NOW(a_miss_index_zero, clk, rst, result_valid && !result.found, result.match_index == '0)
  `STBS_ASSERT_NEXT(a_write_no_result, clk, rst, start && !busy && (in_item.mode == MODE_WRITE), !result_valid)
  `STBS_ASSERT_NEXT(a_write_not_busy, clk, rst, start && !busy && (in_item.mode == MODE_WRITE), !busy)
  `STBS_ASSERT_NOW(a_busy_ends_in_result, clk, rst, $fell(busy), result_valid)

endmodule

bind sorted_table_binary_search_core stbs_checker u_checker (.*);
